// ----- design/mrf_pkg.sv -----
// ----------------------------------------------------------------------------
// mrf_pkg: shared definitions for the message ring FIFO
// Sizes, operation and status codes, register map and the result word type.
// ----------------------------------------------------------------------------
package mrf_pkg;

    // Queue geometry
    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 64;
    localparam int IDX_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);

    // Fixed field widths on the channels
    localparam int DATA_BITS = 64;
    localparam int FILL_BITS = 5;
    localparam int CAP_BITS  = 5;

    // Configuration port
    localparam int ADDR_BITS     = 3;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_SEL_BIT   = 2;

    localparam logic REG_CAPACITY  = 1'b0;
    localparam logic REG_OVERWRITE = 1'b1;

    // Operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic                 status;
        logic [DATA_BITS-1:0] pop_data;
        logic [FILL_BITS-1:0] fill_count;
        logic                 lost_flag;
    } result_t;

endpackage

// ----- design/mrf_if.sv -----
// ----------------------------------------------------------------------------
// mrf_if: command and response channels of the message ring FIFO
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface mrf_cmd_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [mrf_pkg::DATA_BITS-1:0] push_data;

    modport source (output valid, output opcode, output push_data, input ready);
    modport sink   (input valid, input opcode, input push_data, output ready);
endinterface

interface mrf_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          status;
    logic [mrf_pkg::DATA_BITS-1:0] pop_data;
    logic [mrf_pkg::FILL_BITS-1:0] fill_count;
    logic                          lost_flag;

    modport source (output valid, output status, output pop_data,
                    output fill_count, output lost_flag, input ready);
    modport sink   (input valid, input status, input pop_data,
                    input fill_count, input lost_flag, output ready);
endinterface

// ----- design/mrf_out_buf.sv -----
// ----------------------------------------------------------------------------
// mrf_out_buf: two-entry result buffer
// Output register plus a skid register so the input side keeps flowing
// while a finished result waits to be taken.
// ----------------------------------------------------------------------------
module mrf_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  mrf_pkg::result_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output mrf_pkg::result_t out_data
);

    logic             main_valid_reg;
    logic             main_valid_next;
    mrf_pkg::result_t main_data_reg;
    mrf_pkg::result_t main_data_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    mrf_pkg::result_t skid_data_reg;
    mrf_pkg::result_t skid_data_next;
    logic             push;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!main_valid_reg || out_ready)
        begin
            // output slot frees up: refill from skid first, then from input
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                main_valid_next = 1'b1;
                main_data_next  = in_data;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            // output stalled: park the new word
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ----- design/message_ring_fifo_overwrite.sv -----
// ----------------------------------------------------------------------------
// message_ring_fifo_overwrite: ring FIFO of message words with overwrite
// Push/pop queue over a 16-word store with run-time capacity, an optional
// overwrite-oldest mode and a sticky lost-data flag.
// ----------------------------------------------------------------------------
// Each command word is a push (opcode 0) or a pop (opcode 1) and yields
// exactly one response word: status (0 ok, 1 error), the popped word (zero
// on any push or failed pop), the fill count after the operation and the
// sticky lost flag. A command is taken every clock cycle the buffer has
// room: the pointer and count update and the store access all finish in
// the cycle the command is accepted, and the response is registered in a
// two-entry output buffer, so commands keep flowing while one response waits.
// Command ready drops only when both buffer entries are full. The capacity
// register (address 0x0) saturates writes to 1..16 and empties the queue,
// clearing the lost flag; overwrite_enable (address 0x4) takes effect at
// once. Write registers only while no response is outstanding.
// ----------------------------------------------------------------------------
module message_ring_fifo_overwrite (
    input  logic                                  clk,
    input  logic                                  rst_n,
    mrf_cmd_if.sink                               cmd,
    mrf_rsp_if.source                             rsp,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [mrf_pkg::ADDR_BITS-1:0]         paddr,
    input  logic [mrf_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [mrf_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                  pready
);

    // Queue state
    logic [mrf_pkg::WORD_BITS-1:0] slot_reg [mrf_pkg::DEPTH];
    logic [mrf_pkg::IDX_BITS-1:0]  rd_idx_reg;
    logic [mrf_pkg::IDX_BITS-1:0]  rd_idx_next;
    logic [mrf_pkg::IDX_BITS-1:0]  wr_idx_reg;
    logic [mrf_pkg::IDX_BITS-1:0]  wr_idx_next;
    logic [mrf_pkg::CNT_BITS-1:0]  count_reg;
    logic [mrf_pkg::CNT_BITS-1:0]  count_next;
    logic                          lost_reg;
    logic                          lost_next;

    // Configuration registers
    logic [mrf_pkg::CNT_BITS-1:0]  capacity_reg;
    logic [mrf_pkg::CNT_BITS-1:0]  capacity_next;
    logic                          overwrite_reg;
    logic                          overwrite_next;

    logic                          cfg_write;
    logic                          reg_sel;
    logic [mrf_pkg::CAP_BITS-1:0]  cap_wdata;

    logic                          accept;
    logic                          full;
    logic                          store_we;
    logic [mrf_pkg::WORD_BITS-1:0] word;
    mrf_pkg::result_t              result;
    mrf_pkg::result_t              rsp_word;
    logic                          buf_ready;

    // Advance an index by one, wrapping at the configured capacity
    function automatic logic [mrf_pkg::IDX_BITS-1:0] wrap_next(
        input logic [mrf_pkg::IDX_BITS-1:0] idx,
        input logic [mrf_pkg::CNT_BITS-1:0] cap
    );
        logic [mrf_pkg::CNT_BITS:0] n;
        n = (mrf_pkg::CNT_BITS + 1)'(idx) + 1'b1;
        return (n >= (mrf_pkg::CNT_BITS + 1)'(cap)) ? '0 : n[mrf_pkg::IDX_BITS-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration port: two-phase write, zero wait states
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_sel   = paddr[mrf_pkg::REG_SEL_BIT];
    assign cap_wdata = pwdata[mrf_pkg::CAP_BITS-1:0];

    always_comb
    begin
        case (reg_sel)
            mrf_pkg::REG_CAPACITY:  prdata = mrf_pkg::APB_DATA_BITS'(capacity_reg);
            mrf_pkg::REG_OVERWRITE: prdata = mrf_pkg::APB_DATA_BITS'(overwrite_reg);
            default:                prdata = '0;
        endcase
    end

    always_comb
    begin
        capacity_next  = capacity_reg;
        overwrite_next = overwrite_reg;
        if (cfg_write)
        begin
            case (reg_sel)
                mrf_pkg::REG_CAPACITY:
                begin
                    // saturate to 1..DEPTH
                    if (cap_wdata == '0)
                        capacity_next = mrf_pkg::CNT_BITS'(1);
                    else if (32'(cap_wdata) > 32'(mrf_pkg::DEPTH))
                        capacity_next = mrf_pkg::CNT_BITS'(mrf_pkg::DEPTH);
                    else
                        capacity_next = mrf_pkg::CNT_BITS'(cap_wdata);
                end
                mrf_pkg::REG_OVERWRITE: overwrite_next = pwdata[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Queue update: while the response buffer has room, one command per cycle
    // ------------------------------------------------------------------
    assign cmd.ready = buf_ready;
    assign accept    = cmd.valid && cmd.ready;
    assign full      = count_reg >= capacity_reg;
    assign word      = cmd.push_data[mrf_pkg::WORD_BITS-1:0];

    always_comb
    begin
        rd_idx_next       = rd_idx_reg;
        wr_idx_next       = wr_idx_reg;
        count_next        = count_reg;
        lost_next         = lost_reg;
        store_we          = 1'b0;
        result.status     = mrf_pkg::STATUS_OK;
        result.pop_data   = '0;

        if (cfg_write && reg_sel == mrf_pkg::REG_CAPACITY)
        begin
            // new capacity: start over empty
            rd_idx_next = '0;
            wr_idx_next = '0;
            count_next  = '0;
            lost_next   = 1'b0;
        end
        else if (accept)
        begin
            case (cmd.opcode)
                mrf_pkg::OP_PUSH:
                begin
                    if (full)
                    begin
                        lost_next = 1'b1;
                        if (overwrite_reg)
                        begin
                            // drop the oldest, store the new word in its slot
                            store_we    = 1'b1;
                            wr_idx_next = wrap_next(wr_idx_reg, capacity_reg);
                            rd_idx_next = wrap_next(rd_idx_reg, capacity_reg);
                        end
                        else
                        begin
                            result.status = mrf_pkg::STATUS_ERR;
                        end
                    end
                    else
                    begin
                        store_we    = 1'b1;
                        wr_idx_next = wrap_next(wr_idx_reg, capacity_reg);
                        count_next  = count_reg + 1'b1;
                    end
                end
                mrf_pkg::OP_POP:
                begin
                    if (count_reg == '0)
                    begin
                        result.status = mrf_pkg::STATUS_ERR;
                    end
                    else
                    begin
                        result.pop_data = mrf_pkg::DATA_BITS'(slot_reg[rd_idx_reg]);
                        rd_idx_next     = wrap_next(rd_idx_reg, capacity_reg);
                        count_next      = count_reg - 1'b1;
                    end
                end
                default: ;
            endcase
        end

        result.fill_count = mrf_pkg::FILL_BITS'(count_next);
        result.lost_flag  = lost_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            count_reg     <= '0;
            lost_reg      <= 1'b0;
            capacity_reg  <= mrf_pkg::CNT_BITS'(mrf_pkg::DEPTH);
            overwrite_reg <= 1'b0;
        end
        else
        begin
            rd_idx_reg    <= rd_idx_next;
            wr_idx_reg    <= wr_idx_next;
            count_reg     <= count_next;
            lost_reg      <= lost_next;
            capacity_reg  <= capacity_next;
            overwrite_reg <= overwrite_next;
        end
    end

    // Message store: written only at the write index, never reset
    always_ff @(posedge clk)
    begin
        if (store_we)
            slot_reg[wr_idx_reg] <= word;
    end

    // ------------------------------------------------------------------
    // Response buffer
    // ------------------------------------------------------------------
    mrf_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_ready  (buf_ready),
        .in_data   (result),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_data  (rsp_word)
    );

    assign rsp.status     = rsp_word.status;
    assign rsp.pop_data   = rsp_word.pop_data;
    assign rsp.fill_count = rsp_word.fill_count;
    assign rsp.lost_flag  = rsp_word.lost_flag;

endmodule
